// File: sv/tea_pkg.sv
// shared types, constants and round helpers for the tea block cipher
package tea_pkg;

  localparam int unsigned ROUNDS_DEF = 32;

  localparam logic [31:0] TEA_DELTA = 32'h9e37_79b9;

  localparam logic [31:0] KEY0_RST = 32'h95a8_882d;
  localparam logic [31:0] KEY1_RST = 32'h9d2c_c114;
  localparam logic [31:0] KEY2_RST = 32'h815a_a0ce;
  localparam logic [31:0] KEY3_RST = 32'ha1c4_89f8;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0 = 2'd0,
    REG_KEY1 = 2'd1,
    REG_KEY2 = 2'd2,
    REG_KEY3 = 2'd3
  } tea_reg_e;

  typedef enum logic {
    ACT_ENCRYPT = 1'b0,
    ACT_DECRYPT = 1'b1
  } tea_action_e;

  typedef struct packed {
    logic [31:0] k3;
    logic [31:0] k2;
    logic [31:0] k1;
    logic [31:0] k0;
  } tea_key_t;

  // one block in flight: y is the first half, z the second
  typedef struct packed {
    tea_action_e action;
    logic [31:0] y;
    logic [31:0] z;
  } tea_item_t;

  // handshake state handed from the output buffer back to the pipeline
  typedef struct packed {
    logic advance;
  } tea_flow_t;

  // delta times a round count, wrapped to 32 bits
  function automatic logic [31:0] tea_sum(input int unsigned mult);
    logic [63:0] prod;
    prod = 64'(TEA_DELTA) * 64'(mult);
    return prod[31:0];
  endfunction

  function automatic logic [31:0] tea_mix(input logic [31:0] w, input logic [31:0] s,
                                          input logic [31:0] ka, input logic [31:0] kb);
    return ((w << 4) + ka) ^ (w + s) ^ ((w >> 5) + kb);
  endfunction

endpackage

// File: sv/tea_half_round.sv
// one pipeline stage: a single half-round of tea, encrypt or decrypt per beat
module tea_half_round
  import tea_pkg::*;
#(
  parameter bit          PHASE   = 1'b0,
  parameter logic [31:0] SUM_ENC = 32'h0,
  parameter logic [31:0] SUM_DEC = 32'h0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  tea_key_t  key,
  input  logic      in_valid,
  input  tea_item_t in_item,
  output logic      out_valid,
  output tea_item_t out_item
);

  logic        decrypt;
  logic        first_keys;
  logic [31:0] sum;
  logic [31:0] w;
  logic [31:0] ka;
  logic [31:0] kb;
  logic [31:0] mixed;
  logic [31:0] target;
  logic [31:0] updated;
  tea_item_t   item_next;

  always_comb begin
    decrypt    = (in_item.action == ACT_DECRYPT);
    sum        = decrypt ? SUM_DEC : SUM_ENC;
    // encrypt: first half then second; decrypt: second half then first
    first_keys = PHASE ? decrypt : !decrypt;
    w          = first_keys ? in_item.z : in_item.y;
    ka         = first_keys ? key.k0 : key.k2;
    kb         = first_keys ? key.k1 : key.k3;
    target     = first_keys ? in_item.y : in_item.z;
    mixed      = tea_mix(w, sum, ka, kb);
    updated    = decrypt ? (target - mixed) : (target + mixed);
    item_next  = in_item;
    if (first_keys) begin
      item_next.y = updated;
    end else begin
      item_next.z = updated;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= item_next;
    end
  end

endmodule

// File: sv/tea_out_skid.sv
// output register with a skid stage between the pipeline and the master side
module tea_out_skid
  import tea_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  tea_item_t   in_item,
  output tea_flow_t   flow,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata
);

  logic      skid_valid;
  tea_item_t skid_item;
  tea_item_t out_item;
  logic      out_free;
  logic      push;

  assign flow.advance = !skid_valid;
  assign push         = in_valid && !skid_valid;
  assign out_free     = m_tready || !m_tvalid;
  assign m_tdata      = {out_item.z, out_item.y};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_item <= skid_valid ? skid_item : in_item;
    end else if (push) begin
      skid_item <= in_item;
    end
  end

endmodule

// File: sv/tea_block_cipher_top.sv
// top level of the pipelined tea block cipher
//
// tea over one 64-bit block per beat, encrypt or decrypt chosen per beat by
// s_tuser; the pipeline has two stages per round (one per half update); a
// beat passes the half-round registers and then the output register, and a
// new beat is accepted every cycle while the pipeline is not frozen. the
// only stall source is the output skid stage: the pipeline freezes while it
// holds a beat. the 128-bit key sits in four registers written through the
// cfg port; write them only while no beat is in flight
module tea_block_cipher_top
  import tea_pkg::*;
#(
  parameter int unsigned ROUNDS = ROUNDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // key register writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  // input blocks
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [63:0]          s_tdata,   // block_hi [31:0], block_lo [63:32]
  input  logic                 s_tuser,   // action: 0 encrypt, 1 decrypt
  // result blocks
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [63:0]          m_tdata    // result_hi [31:0], result_lo [63:32]
);

  localparam int unsigned NSTAGE = 2 * ROUNDS;

  tea_key_t  key;
  tea_flow_t flow;
  logic      advance;

  // stage 0 is the input beat, stage NSTAGE feeds the output buffer
  logic [NSTAGE:0] stage_valid;
  tea_item_t       stage_item [0:NSTAGE];

  assign advance  = flow.advance;
  assign s_tready = advance;

  assign stage_valid[0]       = s_tvalid;
  assign stage_item[0].action = tea_action_e'(s_tuser);
  assign stage_item[0].y      = s_tdata[31:0];
  assign stage_item[0].z      = s_tdata[63:32];

  // key registers, reset to the default key
  always_ff @(posedge clk) begin
    if (rst) begin
      key.k0 <= KEY0_RST;
      key.k1 <= KEY1_RST;
      key.k2 <= KEY2_RST;
      key.k3 <= KEY3_RST;
    end else if (cfg_we) begin
      case (tea_reg_e'(cfg_index))
        REG_KEY0: key.k0 <= cfg_data;
        REG_KEY1: key.k1 <= cfg_data;
        REG_KEY2: key.k2 <= cfg_data;
        REG_KEY3: key.k3 <= cfg_data;
        default: ;
      endcase
    end
  end

  // round sums are fixed per stage: delta*(r+1) encrypting, delta*(ROUNDS-r) decrypting
  for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
    localparam int unsigned RND = g / 2;

    tea_half_round #(
      .PHASE   (bit'(g % 2)),
      .SUM_ENC (tea_sum(RND + 1)),
      .SUM_DEC (tea_sum(ROUNDS - RND))
    ) u_half (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .key       (key),
      .in_valid  (stage_valid[g]),
      .in_item   (stage_item[g]),
      .out_valid (stage_valid[g+1]),
      .out_item  (stage_item[g+1])
    );
  end

  tea_out_skid u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stage_valid[NSTAGE]),
    .in_item  (stage_item[NSTAGE]),
    .flow     (flow),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // a full skid stage only ever sits behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    !advance |-> m_tvalid)
    else $error("skid stage full while output register empty");

  // a frozen pipeline keeps its last beat intact
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !advance && stage_valid[NSTAGE] |=> stage_valid[NSTAGE] && $stable(stage_item[NSTAGE]))
    else $error("last pipeline stage changed during stall");

  // the pipeline stays frozen while the held output beat is not taken
  a_stall_persists: assert property (@(posedge clk) disable iff (rst)
    !advance && !m_tready |=> !advance)
    else $error("skid stage drained without an output beat");

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for the pipelined tea block cipher top level
module testbench;
  import tea_pkg::*;

  localparam int unsigned NUM_ROUNDS   = ROUNDS_DEF;
  // input to output delay of one beat with the master side ready
  localparam int unsigned PIPE_LAT     = 2 * NUM_ROUNDS + 1;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned MAX_REPORTS  = 30;
  localparam int unsigned BULK_ITEMS   = 1320;
  localparam int unsigned BULK_PHASES  = 6;
  // generous bound on simulated time for a correct run
  localparam longint      RUN_LIMIT    = 64'd4 * 64'd600_000;

  // tdata layout: first half in the low word, second half in the high word
  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
  } block_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [63:0]          s_tdata;   // block_hi [31:0], block_lo [63:32]
  logic                 s_tuser;   // action: 0 encrypt, 1 decrypt
  logic                 m_tvalid;
  logic                 m_tready;
  logic [63:0]          m_tdata;   // result_hi [31:0], result_lo [63:32]

  tea_block_cipher_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // key as the predictor sees it, kept in step with every register write
  tea_key_t    key_now;
  // blocks the cipher still owes us, oldest first
  block_t      pending_blocks[$];
  // recent ciphertexts, fed back as decrypt beats so round trips get exercised
  block_t      cipher_pool[$];
  tea_reg_e    reg_order[4] = '{REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3};

  int unsigned fail_count;
  int unsigned n_reports;
  int unsigned n_checked;
  int unsigned n_encrypt;
  int unsigned n_decrypt;
  int unsigned n_keys;
  int unsigned n_input_stalls;
  bit          idle_en;   // random gaps on both sides
  bit          hold_req;  // asks the receiver for one long hold-off

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------

  // one half-round update term
  function automatic logic [31:0] feistel(input logic [31:0] w, input logic [31:0] s,
                                          input logic [31:0] ka, input logic [31:0] kb);
    return ((w << 4) + ka) ^ (w + s) ^ ((w >> 5) + kb);
  endfunction

  function automatic block_t tea_predict(input tea_action_e act, input block_t blk,
                                         input tea_key_t k);
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] acc;
    block_t      res;
    y = blk.hi;
    z = blk.lo;
    if (act == ACT_ENCRYPT) begin
      acc = '0;
      repeat (NUM_ROUNDS) begin
        acc = acc + TEA_DELTA;
        y   = y + feistel(z, acc, k.k0, k.k1);
        z   = z + feistel(y, acc, k.k2, k.k3);
      end
    end else begin
      // start sum wraps: delta times the round count, low 32 bits only
      acc = TEA_DELTA * NUM_ROUNDS;
      repeat (NUM_ROUNDS) begin
        z   = z - feistel(y, acc, k.k2, k.k3);
        y   = y - feistel(z, acc, k.k0, k.k1);
        acc = acc - TEA_DELTA;
      end
    end
    res.hi = y;
    res.lo = z;
    return res;
  endfunction

  // mostly uniform words, with a share of edge patterns
  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0:       w = 32'h0000_0000;
      1:       w = 32'hffff_ffff;
      2:       w = 32'h1 << $urandom_range(0, 31);
      3:       w = ~(32'h1 << $urandom_range(0, 31));
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // ---------------------------------------------------------------------
  // shared drivers
  // ---------------------------------------------------------------------

  // offer one beat, wait for the handshake, then book its expected result
  task automatic send_block(input tea_action_e act, input block_t blk);
    block_t res;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= blk;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    res = tea_predict(act, blk, key_now);
    pending_blocks.push_back(res);
    if (act == ACT_ENCRYPT) begin
      n_encrypt++;
      cipher_pool.push_back(res);
      if (cipher_pool.size() > 64) void'(cipher_pool.pop_front());
    end else begin
      n_decrypt++;
    end
  endtask

  // stop offering and let the pipeline run dry
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write the key registers picked by mask; only called with nothing in flight
  task automatic load_key(input tea_key_t k, input logic [3:0] mask);
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        cfg_we    <= 1'b1;
        cfg_index <= reg_order[i];
        cfg_data  <= k[32*i +: 32];
        @(posedge clk);
        key_now[32*i +: 32] = k[32*i +: 32];
      end
    end
    cfg_we <= 1'b0;
    n_keys++;
    @(posedge clk);
  endtask

  task automatic send_random(input int unsigned count);
    block_t blk;
    for (int unsigned n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        // decrypt a block we encrypted earlier, possibly under an older key
        0, 1, 2: begin
          if (cipher_pool.size() != 0) begin
            blk = cipher_pool[$urandom_range(0, cipher_pool.size() - 1)];
            send_block(ACT_DECRYPT, blk);
          end else begin
            blk = {pick_word(), pick_word()};
            send_block(ACT_DECRYPT, blk);
          end
        end
        3, 4, 5: begin
          blk = {pick_word(), pick_word()};
          send_block(ACT_DECRYPT, blk);
        end
        default: begin
          blk = {pick_word(), pick_word()};
          send_block(ACT_ENCRYPT, blk);
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // reset key, edge blocks in both directions plus one round trip
  task automatic test_reset_key();
    block_t edge_blocks[8];
    block_t ct;
    edge_blocks = '{
      {32'h0000_0000, 32'h0000_0000}, {32'hffff_ffff, 32'hffff_ffff},
      {32'hffff_ffff, 32'h0000_0000}, {32'h0000_0000, 32'hffff_ffff},
      {32'h0000_0001, 32'h8000_0000}, {32'h5555_5555, 32'haaaa_aaaa},
      {32'h89ab_cdef, 32'h0123_4567}, {32'h8000_0000, 32'h0000_0001}
    };
    foreach (edge_blocks[i]) send_block(ACT_ENCRYPT, edge_blocks[i]);
    foreach (edge_blocks[i]) send_block(ACT_DECRYPT, edge_blocks[i]);
    ct = tea_predict(ACT_ENCRYPT, edge_blocks[6], key_now);
    send_block(ACT_DECRYPT, ct);
    wait_idle();
  endtask

  // extreme keys, then each register on its own so a stuck index shows up
  task automatic test_key_writes();
    tea_key_t k;
    load_key('0, 4'b1111);
    send_random(20);
    wait_idle();
    load_key('1, 4'b1111);
    send_random(20);
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      k = {$urandom, $urandom, $urandom, $urandom};
      load_key(k, 4'b0001 << i);
      send_random(15);
      wait_idle();
    end
    k = {4{32'h8000_0000}};
    load_key(k, 4'b1111);
    send_random(15);
    wait_idle();
  endtask

  // receiver holds off for a long stretch while beats keep coming
  task automatic test_backpressure();
    idle_en  = 1'b0;
    hold_req = 1'b1;
    send_random(250);
    wait_idle();
    idle_en  = 1'b1;
  endtask

  // bulk traffic over several random keys; the last phase runs flat out
  task automatic test_bulk();
    tea_key_t k;
    int unsigned per_phase;
    per_phase = BULK_ITEMS / BULK_PHASES;
    for (int unsigned p = 0; p < BULK_PHASES; p++) begin
      k = {$urandom, $urandom, $urandom, $urandom};
      load_key(k, (p % 2 == 0) ? 4'b1111 : 4'($urandom_range(1, 15)));
      if (p == BULK_PHASES - 1) idle_en = 1'b0;
      send_random(per_phase);
      wait_idle();
    end
  endtask

  // ---------------------------------------------------------------------
  // receiver: random stalls, one long hold-off on request
  // ---------------------------------------------------------------------
  initial begin
    m_tready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------
  // result checker: every accepted output beat against the oldest prediction
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    block_t got;
    block_t want;
    if (!rst) begin
      if (s_tvalid && !s_tready) n_input_stalls++;
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_blocks.size() == 0) begin
          fail_count++;
          if (n_reports < MAX_REPORTS) begin
            n_reports++;
            $display("%0t: unexpected result beat, actual hi %h lo %h",
                     $time, got.hi, got.lo);
          end
        end else begin
          want = pending_blocks.pop_front();
          n_checked++;
          if (got.hi !== want.hi) begin
            fail_count++;
            if (n_reports < MAX_REPORTS) begin
              n_reports++;
              $display("%0t: result_hi mismatch, expected %h actual %h",
                       $time, want.hi, got.hi);
            end
          end
          if (got.lo !== want.lo) begin
            fail_count++;
            if (n_reports < MAX_REPORTS) begin
              n_reports++;
              $display("%0t: result_lo mismatch, expected %h actual %h",
                       $time, want.lo, got.lo);
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // run limit
  // ---------------------------------------------------------------------
  initial begin
    #(RUN_LIMIT);
    $display("%0t: run limit reached with %0d results outstanding",
             $time, pending_blocks.size());
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    clk            = 1'b0;
    fail_count     = 0;
    n_reports      = 0;
    n_checked      = 0;
    n_encrypt      = 0;
    n_decrypt      = 0;
    n_keys         = 0;
    n_input_stalls = 0;
    idle_en        = 1'b1;
    hold_req       = 1'b0;
    key_now        = {KEY3_RST, KEY2_RST, KEY1_RST, KEY0_RST};
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_KEY0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= ACT_ENCRYPT;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_key();
    test_key_writes();
    test_backpressure();
    test_bulk();

    // drain, then give any stray beat time to show itself
    wait_idle();
    repeat (PIPE_LAT + 16) @(posedge clk);
    fail_count += pending_blocks.size();

    $display("checked %0d result beats: %0d encrypted, %0d decrypted, %0d key loads",
             n_checked, n_encrypt, n_decrypt, n_keys);
    $display("input side stalled for %0d cycles under output back-pressure",
             n_input_stalls);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
